// ===== design/cps_pkg.sv =====
// Package for the closest-point-on-segment pipeline: word types and region codes.
// No dependencies.
`timescale 1ns / 1ps
package cps_pkg;

    localparam int CoordBitsDef = 32;
    localparam int FracBitsDef  = 16;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2,
        REGION_ZERO     = 2'd3
    } region_t;

    typedef struct packed {
        logic signed [CoordBitsDef-1:0] start_x;
        logic signed [CoordBitsDef-1:0] start_y;
        logic signed [CoordBitsDef-1:0] start_z;
        logic signed [CoordBitsDef-1:0] end_x;
        logic signed [CoordBitsDef-1:0] end_y;
        logic signed [CoordBitsDef-1:0] end_z;
        logic signed [CoordBitsDef-1:0] ref_x;
        logic signed [CoordBitsDef-1:0] ref_y;
        logic signed [CoordBitsDef-1:0] ref_z;
    } in_word_t;

    typedef struct packed {
        logic signed [CoordBitsDef-1:0] closest_x;
        logic signed [CoordBitsDef-1:0] closest_y;
        logic signed [CoordBitsDef-1:0] closest_z;
        logic [1:0]                     region;
    } out_word_t;

endpackage

// ===== design/cps_divstage.sv =====
// One restoring-division step for the fraction of the projection ratio.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module cps_divstage #(
    parameter int W = 70,
    parameter int Q = 16
) (
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] den,
    input  logic [Q-1:0] q_in,
    output logic [W-1:0] rem_out,
    output logic [Q-1:0] q_out
);
    logic [W:0] shifted;
    logic [W:0] diff;

    // The remainder stays below den, so one extra bit holds the shifted value.
    assign shifted = {rem_in, 1'b0};
    assign diff    = shifted - {1'b0, den};
    assign rem_out = diff[W] ? shifted[W-1:0] : diff[W-1:0];
    assign q_out   = {q_in[Q-2:0], ~diff[W]};
endmodule

// ===== design/closest_point_on_segment.sv =====
// Closest point on a 3D segment: a fully pipelined stream block taking one word per
// cycle. Its registers in order: difference, products, sums, classification into the
// first divider register, one register per quotient bit of the restoring divider (its
// chain sets the depth), the interior multiply, then the final add into the output
// register. A stall freezes the whole pipe; nothing is lost.
// Depends on cps_pkg and cps_divstage.
`timescale 1ns / 1ps
module closest_point_on_segment
    import cps_pkg::*;
#(
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);
    localparam int CB  = CoordBitsDef;
    localparam int DB  = CB + 1;          // difference width
    localparam int PB  = 2 * DB;          // product width
    localparam int SB  = PB + 2;          // sum of three products
    localparam int NS  = FRAC_BITS;       // divider stages
    localparam int LAT = NS + 6;

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = ~vld_reg[LAT-1] | out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Stage 1: sign-extended coordinates and differences.
    logic signed [CB-1:0] s1_s_reg [3];
    logic signed [CB-1:0] s1_e_reg [3];
    logic signed [DB-1:0] s1_d_reg [3];
    logic signed [DB-1:0] s1_r_reg [3];
    logic signed [CB-1:0] in_s [3];
    logic signed [CB-1:0] in_e [3];
    logic signed [CB-1:0] in_p [3];

    always_comb
    begin
        in_s[0] = in_word.start_x[CB-1:0];
        in_s[1] = in_word.start_y[CB-1:0];
        in_s[2] = in_word.start_z[CB-1:0];
        in_e[0] = in_word.end_x[CB-1:0];
        in_e[1] = in_word.end_y[CB-1:0];
        in_e[2] = in_word.end_z[CB-1:0];
        in_p[0] = in_word.ref_x[CB-1:0];
        in_p[1] = in_word.ref_y[CB-1:0];
        in_p[2] = in_word.ref_z[CB-1:0];
    end

    // Stage 2: products.
    logic signed [PB-1:0] s2_num_reg [3];
    logic signed [PB-1:0] s2_den_reg [3];
    logic signed [CB-1:0] s2_s_reg [3];
    logic signed [CB-1:0] s2_e_reg [3];
    logic signed [DB-1:0] s2_d_reg [3];

    // Stage 3: dot products.
    logic signed [SB-1:0] s3_num_reg;
    logic [SB-1:0]        s3_den_reg;
    logic signed [CB-1:0] s3_s_reg [3];
    logic signed [CB-1:0] s3_e_reg [3];
    logic signed [DB-1:0] s3_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_s_reg[i] <= in_s[i];
                s1_e_reg[i] <= in_e[i];
                s1_d_reg[i] <= DB'(in_e[i]) - DB'(in_s[i]);
                s1_r_reg[i] <= DB'(in_p[i]) - DB'(in_s[i]);
                s2_num_reg[i] <= PB'(s1_r_reg[i]) * PB'(s1_d_reg[i]);
                s2_den_reg[i] <= PB'(s1_d_reg[i]) * PB'(s1_d_reg[i]);
                s2_s_reg[i] <= s1_s_reg[i];
                s2_e_reg[i] <= s1_e_reg[i];
                s2_d_reg[i] <= s1_d_reg[i];
                s3_s_reg[i] <= s2_s_reg[i];
                s3_e_reg[i] <= s2_e_reg[i];
                s3_d_reg[i] <= s2_d_reg[i];
            end
            s3_num_reg <= SB'(s2_num_reg[0]) + SB'(s2_num_reg[1]) + SB'(s2_num_reg[2]);
            s3_den_reg <= SB'(s2_den_reg[0]) + SB'(s2_den_reg[1]) + SB'(s2_den_reg[2]);
        end
    end

    // Stage 4: classification; the interior result is decided later.
    logic [1:0]           region_next;
    always_comb
    begin
        if (s3_den_reg == '0)
            region_next = REGION_ZERO;
        else if (s3_num_reg[SB-1] || s3_num_reg == '0)
            region_next = REGION_START;
        else if ($unsigned(s3_num_reg) >= s3_den_reg)
            region_next = REGION_END;
        else
            region_next = REGION_INTERIOR;
    end

    // Divider chain, one quotient bit per register stage.
    logic [SB-1:0]        dv_rem_reg [NS+1];
    logic [SB-1:0]        dv_den_reg [NS+1];
    logic [NS-1:0]        dv_q_reg   [NS+1];
    logic [1:0]           dv_reg_reg [NS+1];
    logic signed [DB-1:0] dv_d_reg   [NS+1][3];
    // Coordinates ride along beside the chain.
    logic signed [CB-1:0] cs_reg [NS+1][3];
    logic signed [CB-1:0] ce_reg [NS+1][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Only interior words use the remainder, which is then below den.
            dv_rem_reg[0] <= (region_next == REGION_INTERIOR) ? s3_num_reg : '0;
            dv_den_reg[0] <= s3_den_reg;
            dv_q_reg[0]   <= '0;
            dv_reg_reg[0] <= region_next;
            for (int i = 0; i < 3; i++)
            begin
                dv_d_reg[0][i] <= s3_d_reg[i];
                cs_reg[0][i]   <= s3_s_reg[i];
                ce_reg[0][i]   <= s3_e_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_div
        logic [SB-1:0] rem_n;
        logic [NS-1:0] q_n;
        cps_divstage #(.W(SB), .Q(NS)) u_step (
            .rem_in (dv_rem_reg[g]),
            .den    (dv_den_reg[g]),
            .q_in   (dv_q_reg[g]),
            .rem_out(rem_n),
            .q_out  (q_n)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[g+1] <= rem_n;
                dv_den_reg[g+1] <= dv_den_reg[g];
                dv_q_reg[g+1]   <= q_n;
                dv_reg_reg[g+1] <= dv_reg_reg[g];
                for (int i = 0; i < 3; i++)
                begin
                    dv_d_reg[g+1][i] <= dv_d_reg[g][i];
                    cs_reg[g+1][i]   <= cs_reg[g][i];
                    ce_reg[g+1][i]   <= ce_reg[g][i];
                end
            end
        end
    end

    // Stage after the divider: signed products D_i * q, truncated toward zero.
    localparam int MB = DB + NS + 1;
    logic [MB-1:0]        m_mag_reg [3];
    logic [2:0]           m_neg_reg;
    logic [1:0]           m_region_reg;
    logic signed [CB-1:0] m_s_reg [3];
    logic signed [CB-1:0] m_e_reg [3];
    logic [DB-1:0]        d_mag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_mag[i] = dv_d_reg[NS][i][DB-1] ? -dv_d_reg[NS][i] : dv_d_reg[NS][i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_mag_reg[i] <= MB'(d_mag[i]) * MB'(dv_q_reg[NS]);
                m_neg_reg[i] <= dv_d_reg[NS][i][DB-1];
                m_s_reg[i]   <= cs_reg[NS][i];
                m_e_reg[i]   <= ce_reg[NS][i];
            end
            m_region_reg <= dv_reg_reg[NS];
        end
    end

    // Final add and selection into the output register.
    logic signed [CB-1:0] res [3];
    logic [CB-1:0]        stp [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            stp[i] = CB'(m_mag_reg[i] >> NS);
            if (m_neg_reg[i])
                stp[i] = -stp[i];
            case (m_region_reg)
                REGION_END:      res[i] = m_e_reg[i];
                REGION_INTERIOR: res[i] = m_s_reg[i] + stp[i];
                default:         res[i] = m_s_reg[i];
            endcase
        end
    end

    out_word_t o_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg.closest_x <= res[0];
            o_reg.closest_y <= res[1];
            o_reg.closest_z <= res[2];
            o_reg.region    <= m_region_reg;
        end
    end
    assign out_word = o_reg;

    // A stalled output must hold its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed under stall");
    // The valid bits stay put while the pipe is frozen.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready not tied to output slot");
endmodule

// ===== dv/tb_closest_point_on_segment.sv =====
// Self-checking testbench for closest_point_on_segment: random and directed segment queries.
// Depends on cps_pkg and the closest_point_on_segment RTL.
`timescale 1ns / 1ps
module tb_closest_point_on_segment;
    import cps_pkg::*;

    localparam int Latency       = 6 + FracBitsDef;
    localparam int HoldOffCycles = 4 * Latency + 20;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    in_word_t  pending_words[$];
    out_word_t expected_points[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_count = 0;
    bit        long_hold;
    bit        in_taken;
    int        error_count;

    closest_point_on_segment DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Exact projection with 128-bit sums; the quotient comes from a long division.
    function automatic out_word_t project_point(in_word_t w);
        logic signed [31:0]  s[3];
        logic signed [31:0]  e[3];
        logic signed [31:0]  p[3];
        logic signed [32:0]  d[3];
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic [127:0]        rem;
        logic [FracBitsDef-1:0] q;
        logic signed [127:0] prod;
        logic signed [127:0] step;
        out_word_t           r;
        s = '{w.start_x, w.start_y, w.start_z};
        e = '{w.end_x, w.end_y, w.end_z};
        p = '{w.ref_x, w.ref_y, w.ref_z};
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 33'(e[i]) - 33'(s[i]);
            num += 128'(34'(p[i]) - 34'(s[i])) * 128'(d[i]);
            den += 128'(d[i]) * 128'(d[i]);
        end
        if (den == 0)
        begin
            r = '{s[0], s[1], s[2], REGION_ZERO};
        end
        else if (num <= 0)
        begin
            r = '{s[0], s[1], s[2], REGION_START};
        end
        else if (num >= den)
        begin
            r = '{e[0], e[1], e[2], REGION_END};
        end
        else
        begin
            rem = num;
            q = '0;
            for (int b = 0; b < FracBitsDef; b++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den)
                begin
                    rem -= den;
                    q[0] = 1'b1;
                end
            end
            r.region = REGION_INTERIOR;
            for (int i = 0; i < 3; i++)
            begin
                prod = 128'(d[i]) * $signed({1'b0, q});
                // Truncate toward zero: scale the magnitude, then restore the sign.
                step = prod < 0 ? -((-prod) >>> FracBitsDef) : prod >>> FracBitsDef;
                if (i == 0) r.closest_x = 32'(128'(s[i]) + step);
                if (i == 1) r.closest_y = 32'(128'(s[i]) + step);
                if (i == 2) r.closest_z = 32'(128'(s[i]) + step);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic in_word_t rand_query();
        in_word_t w;
        int       mode;
        mode = $urandom_range(0, 2);
        w = '{rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        case ($urandom_range(0, 9))
            0: {w.end_x, w.end_y, w.end_z} = {w.start_x, w.start_y, w.start_z};
            1:
            begin
                // Reference near the midpoint lands mostly in the interior.
                w.ref_x = 32'((64'(w.start_x) + 64'(w.end_x)) >>> 1);
                w.ref_y = 32'((64'(w.start_y) + 64'(w.end_y)) >>> 1) + rand_coord(2);
                w.ref_z = 32'((64'(w.start_z) + 64'(w.end_z)) >>> 1);
            end
            default: ;
        endcase
        return w;
    endfunction

    // Driver: offers the head of the queue and keeps it steady until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && in_taken)
            pending_words.pop_front();
        if (!in_valid || in_taken)
        begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_word  <= pending_words[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (long_hold && hold_count < HoldOffCycles)
        begin
            out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_points.push_back(project_point(in_word));
    end

    // Monitor.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("Result word with nothing expected: %p", out_word);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_word.closest_x !== want.closest_x)
                begin
                    $error("closest_x expected %0d got %0d", want.closest_x, out_word.closest_x);
                    error_count++;
                end
                if (out_word.closest_y !== want.closest_y)
                begin
                    $error("closest_y expected %0d got %0d", want.closest_y, out_word.closest_y);
                    error_count++;
                end
                if (out_word.closest_z !== want.closest_z)
                begin
                    $error("closest_z expected %0d got %0d", want.closest_z, out_word.closest_z);
                    error_count++;
                end
                if (out_word.region !== want.region)
                begin
                    $error("region expected %0d got %0d", want.region, out_word.region);
                    error_count++;
                end
            end
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            pending_words.push_back(rand_query());
        while (pending_words.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        in_taken = 1'b0;
        error_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, each region, zero length, and tiny interior ratio.
        pending_words.push_back('0);
        pending_words.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h0, 32'h0, 32'h0});
        pending_words.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_words.push_back('{0, 0, 0, 32'h10000, 0, 0, 32'hffff_0000, 5, 5});
        pending_words.push_back('{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 5, 5});
        pending_words.push_back('{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 5, 5});
        pending_words.push_back('{0, 0, 0, 32'h10000, 0, 0, 32'h8000, 7, 7});
        pending_words.push_back('{0, 0, 0, 32'h7fff_0000, 0, 0, 1, 0, 0});
        pending_words.push_back('{-32'sd3, 0, 0, 32'h8000_0000, 2, 9, 32'h7fff_ffff, 0, 0});
        pending_words.push_back('{5, 6, 7, 5, 6, 7, 32'h7fff_ffff, 32'h8000_0000, 0});
        pending_words.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        pending_words.push_back('{0, 0, 0, 0, 0, 3, 0, 0, 1});
        pending_words.push_back('{0, 0, 0, 0, -32'sd3, 0, 0, -32'sd2, 0});
        while (pending_words.size() > 0)
            @(posedge clk);

        run_phase(0, 0, 150);
        run_phase(85, 0, 100);
        run_phase(0, 85, 100);
        run_phase(35, 35, 100);

        // Long receiver hold-off while the sender keeps offering words.
        @(negedge clk);
        long_hold = 1'b1;
        run_phase(0, 0, 100);

        while (expected_points.size() > 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== closest_point_on_segment.f =====
design/cps_pkg.sv
design/cps_divstage.sv
design/closest_point_on_segment.sv
dv/tb_closest_point_on_segment.sv
